### src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("checker assertion failed");

// next-cycle implication, disabled while reset is active
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("checker assertion failed");

`endif

### src/pwli_pkg.sv
package pwli_pkg;

	localparam int MAX_POINTS = 16;
	localparam int PT_W       = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int IDX_W      = 4;
	localparam int DATA_W     = 32;
	localparam int DIFF_W     = DATA_W + 1;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int DIV_CYCLES = PROD_W / 2;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
	localparam int CFG_W      = 5;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic {
		FUNC_WRITE  = 1'b0,
		FUNC_LOOKUP = 1'b1
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POINT_COUNT = 2'd0,
		REG_EDGE_MODE   = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EDGE_ERROR  = 2'd0,
		EDGE_CLIP   = 2'd1,
		EDGE_EXTRAP = 2'd2
	} edge_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_WALK,
		ST_DIFF,
		ST_SCALE,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_RUN,
		MD_ROUND
	} md_state_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] mag_a;
		logic [DATA_W-1:0] mag_b;
		logic [DATA_W-1:0] den;
	} md_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quot;
	} md_rsp_t;

endpackage

### src/pwli_req_if.sv
interface pwli_req_if;
	logic                              valid;
	logic                              ready;
	logic                              func;
	logic [pwli_pkg::IDX_W-1:0]        point_index;
	logic signed [pwli_pkg::DATA_W-1:0] x_value;
	logic signed [pwli_pkg::DATA_W-1:0] y_value;

	modport source (output valid, func, point_index, x_value, y_value, input ready);
	modport sink   (input valid, func, point_index, x_value, y_value, output ready);
endinterface

### src/pwli_rsp_if.sv
interface pwli_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [pwli_pkg::DATA_W-1:0] y_result;
	logic                               failed;

	modport source (output valid, y_result, failed, input ready);
	modport sink   (input valid, y_result, failed, output ready);
endinterface

### src/pwli_table.sv
module pwli_table (
	input  logic                               clk,
	input  logic                               we,
	input  logic [pwli_pkg::PT_W-1:0]          waddr,
	input  logic signed [pwli_pkg::DATA_W-1:0] wx,
	input  logic signed [pwli_pkg::DATA_W-1:0] wy,
	input  logic                               re,
	input  logic [pwli_pkg::PT_W-1:0]          raddr,
	output logic signed [pwli_pkg::DATA_W-1:0] rx,
	output logic signed [pwli_pkg::DATA_W-1:0] ry
);

	logic signed [pwli_pkg::DATA_W-1:0] x_mem [pwli_pkg::MAX_POINTS];
	logic signed [pwli_pkg::DATA_W-1:0] y_mem [pwli_pkg::MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			x_mem[waddr] <= wx;
			y_mem[waddr] <= wy;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rx <= x_mem[raddr];
			ry <= y_mem[raddr];
		end
	end

endmodule

### src/pwli_muldiv.sv
module pwli_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  pwli_pkg::md_req_t md_req,
	output pwli_pkg::md_rsp_t md_rsp
);

	localparam int DW = pwli_pkg::DATA_W;

	pwli_pkg::md_state_t state_q, state_d;

	logic [DW-1:0]                  a_q, b_q, den_q;
	logic [pwli_pkg::PROD_W-1:0]    dvd_q;
	logic [DW-1:0]                  rem_q;
	logic [pwli_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [DW-1:0]                  quot_q;
	logic                           done_q;

	logic [DW:0]                 r1, r1s, r2, r2s;
	logic                        q1, q2;
	logic [DW-1:0]               rem1, rem2;
	logic [pwli_pkg::PROD_W-1:0] d1, d2;
	logic                        rnd_up;
	logic                        last_step;

	// two restoring steps per cycle
	always_comb begin
		r1   = {rem_q, dvd_q[pwli_pkg::PROD_W-1]};
		q1   = r1 >= {1'b0, den_q};
		r1s  = q1 ? r1 - {1'b0, den_q} : r1;
		rem1 = r1s[DW-1:0];
		d1   = {dvd_q[pwli_pkg::PROD_W-2:0], q1};
		r2   = {rem1, d1[pwli_pkg::PROD_W-1]};
		q2   = r2 >= {1'b0, den_q};
		r2s  = q2 ? r2 - {1'b0, den_q} : r2;
		rem2 = r2s[DW-1:0];
		d2   = {d1[pwli_pkg::PROD_W-2:0], q2};
	end

	assign rnd_up    = {rem_q, 1'b0} >= {1'b0, den_q};
	assign last_step = cnt_q == pwli_pkg::DIV_CNT_W'(pwli_pkg::DIV_CYCLES - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pwli_pkg::MD_IDLE:  if (md_req.start) state_d = pwli_pkg::MD_MUL;
			pwli_pkg::MD_MUL:   state_d = pwli_pkg::MD_RUN;
			pwli_pkg::MD_RUN:   if (last_step) state_d = pwli_pkg::MD_ROUND;
			pwli_pkg::MD_ROUND: state_d = pwli_pkg::MD_IDLE;
			default:            state_d = pwli_pkg::MD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwli_pkg::MD_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == pwli_pkg::MD_ROUND;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pwli_pkg::MD_IDLE: begin
				a_q   <= md_req.mag_a;
				b_q   <= md_req.mag_b;
				den_q <= md_req.den;
			end
			pwli_pkg::MD_MUL: begin
				dvd_q <= a_q * b_q;
				rem_q <= '0;
				cnt_q <= '0;
			end
			pwli_pkg::MD_RUN: begin
				dvd_q <= d2;
				rem_q <= rem2;
				cnt_q <= cnt_q + pwli_pkg::DIV_CNT_W'(1);
			end
			pwli_pkg::MD_ROUND: begin
				// ties round away from zero on the magnitude
				quot_q <= dvd_q[DW-1:0] + DW'(rnd_up);
			end
			default: begin
			end
		endcase
	end

	assign md_rsp.done = done_q;
	assign md_rsp.quot = quot_q;

endmodule

### src/piecewise_linear_table_interp_core.sv
// Piecewise linear lookup over a table of up to sixteen (x, y) breakpoints with monotonic x,
// held in a synchronous two-port table memory. A write item stores one point and returns a
// zero result through the finish state and the output register. A lookup reads the table
// one point a cycle, walking segments in order, and ends on an exact breakpoint hit, a clip
// or an error. When it has to interpolate it forms the differences and magnitudes, then uses
// the multiply and divide unit (the 32x32 product, restoring divide steps of two quotient
// bits each, a rounding step and a registered handback of the quotient); a flat segment
// skips the divide. One item is in work at a time; the next item is taken while the previous
// result still waits in the output register. point_count is clamped to 2..16 and edge_mode 3
// acts as extrapolate. Configuration is to be written by the user only while no item is in
// work; the core itself does not enforce it.
module piecewise_linear_table_interp_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pwli_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pwli_pkg::CFG_W-1:0]       cfg_wdata,
	pwli_req_if.sink                         req,
	pwli_rsp_if.source                       rsp
);

	localparam int DW = pwli_pkg::DATA_W;
	localparam int PW = pwli_pkg::PT_W;
	localparam int CW = pwli_pkg::CNT_W;

	function automatic logic [DW-1:0] mag33(input logic [pwli_pkg::DIFF_W-1:0] v);
		logic [pwli_pkg::DIFF_W-1:0] t;
		t = v[pwli_pkg::DIFF_W-1] ? (~v + pwli_pkg::DIFF_W'(1)) : v;
		return t[DW-1:0];
	endfunction

	function automatic logic [CW-1:0] clamp_count(input logic [pwli_pkg::CFG_W-1:0] v);
		logic [CW-1:0] r;
		if (int'(v) < 2) r = CW'(2);
		else if (int'(v) > pwli_pkg::MAX_POINTS) r = CW'(pwli_pkg::MAX_POINTS);
		else r = CW'(v);
		return r;
	endfunction

	pwli_pkg::state_t state_q, state_d;

	logic [CW-1:0] n_q;
	logic [1:0]    mode_q;

	logic signed [DW-1:0]           x_q, a_x_q, a_y_q, b_x_q, b_y_q;
	logic [PW-1:0]                  i_q;
	logic [pwli_pkg::DIFF_W-1:0]    dx_q, dy_q, dd_q;
	logic                           neg_q;
	logic [DW-1:0]                  res_y_q;
	logic                           res_fail_q;

	logic          out_valid_q;
	logic [DW-1:0] out_y_q;
	logic          out_fail_q;
	logic          out_free;

	logic                 tbl_we, tbl_re;
	logic [PW-1:0]        tbl_raddr;
	logic signed [DW-1:0] rd_x, rd_y;

	pwli_pkg::md_req_t md_req;
	pwli_pkg::md_rsp_t md_rsp;

	logic          accept;
	logic          eq_a, eq_b, lt_a, lt_b, gt_b, a_lt_b;
	logic          below, between, above, last_seg;
	logic          fin, fin_fail, go_seg, go_next;
	logic [DW-1:0] fin_y;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	pwli_table u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (req.point_index[PW-1:0]),
		.wx    (req.x_value),
		.wy    (req.y_value),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rx    (rd_x),
		.ry    (rd_y)
	);

	pwli_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.md_req (md_req),
		.md_rsp (md_rsp)
	);

	assign md_req.start = state_q == pwli_pkg::ST_SCALE && dd_q != '0;
	assign md_req.mag_a = mag33(dx_q);
	assign md_req.mag_b = mag33(dy_q);
	assign md_req.den   = mag33(dd_q);

	// segment walk: a is point i in registers, b is point i+1 from the table
	always_comb begin
		eq_a     = x_q == a_x_q;
		eq_b     = x_q == rd_x;
		lt_a     = x_q < a_x_q;
		lt_b     = x_q < rd_x;
		gt_b     = rd_x < x_q;
		a_lt_b   = a_x_q < rd_x;
		below    = lt_a == a_lt_b;
		between  = lt_a != lt_b;
		above    = gt_b == a_lt_b;
		last_seg = (CW'(i_q) + CW'(2)) >= n_q;

		fin      = 1'b0;
		fin_fail = 1'b0;
		fin_y    = '0;
		go_seg   = 1'b0;
		go_next  = 1'b0;
		if (eq_a) begin
			fin   = 1'b1;
			fin_y = a_y_q;
		end else if (eq_b) begin
			fin   = 1'b1;
			fin_y = rd_y;
		end else if (i_q == '0 && below) begin
			if (mode_q == pwli_pkg::EDGE_ERROR) begin
				fin      = 1'b1;
				fin_fail = 1'b1;
			end else if (mode_q == pwli_pkg::EDGE_CLIP) begin
				fin   = 1'b1;
				fin_y = a_y_q;
			end else begin
				go_seg = 1'b1;
			end
		end else if (between) begin
			go_seg = 1'b1;
		end else if (last_seg) begin
			if (above && mode_q == pwli_pkg::EDGE_ERROR) begin
				fin      = 1'b1;
				fin_fail = 1'b1;
			end else if (above && mode_q == pwli_pkg::EDGE_CLIP) begin
				fin   = 1'b1;
				fin_y = rd_y;
			end else begin
				go_seg = 1'b1;
			end
		end else begin
			go_next = 1'b1;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		tbl_we    = 1'b0;
		tbl_re    = 1'b0;
		tbl_raddr = '0;
		unique case (state_q)
			pwli_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.func == pwli_pkg::FUNC_WRITE) begin
						tbl_we  = int'(req.point_index) < pwli_pkg::MAX_POINTS;
						state_d = pwli_pkg::ST_FINISH;
					end else begin
						tbl_re  = 1'b1;
						state_d = pwli_pkg::ST_LOAD;
					end
				end
			end
			pwli_pkg::ST_LOAD: begin
				tbl_re    = 1'b1;
				tbl_raddr = PW'(1);
				state_d   = pwli_pkg::ST_WALK;
			end
			pwli_pkg::ST_WALK: begin
				if (fin) begin
					state_d = pwli_pkg::ST_FINISH;
				end else if (go_seg) begin
					state_d = pwli_pkg::ST_DIFF;
				end else begin
					tbl_re    = go_next;
					tbl_raddr = i_q + PW'(2);
				end
			end
			pwli_pkg::ST_DIFF: state_d = pwli_pkg::ST_SCALE;
			pwli_pkg::ST_SCALE: begin
				state_d = (dd_q == '0) ? pwli_pkg::ST_FINISH : pwli_pkg::ST_DIV;
			end
			pwli_pkg::ST_DIV: if (md_rsp.done) state_d = pwli_pkg::ST_FINISH;
			pwli_pkg::ST_FINISH: if (out_free) state_d = pwli_pkg::ST_IDLE;
			default: state_d = pwli_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwli_pkg::ST_IDLE;
			n_q     <= CW'(2);
			mode_q  <= pwli_pkg::EDGE_CLIP;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					pwli_pkg::REG_POINT_COUNT: n_q <= clamp_count(cfg_wdata);
					pwli_pkg::REG_EDGE_MODE:   mode_q <= cfg_wdata[1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pwli_pkg::ST_IDLE: begin
				x_q        <= req.x_value;
				i_q        <= '0;
				res_y_q    <= '0;
				res_fail_q <= 1'b0;
			end
			pwli_pkg::ST_LOAD: begin
				a_x_q <= rd_x;
				a_y_q <= rd_y;
			end
			pwli_pkg::ST_WALK: begin
				if (go_next) begin
					a_x_q <= rd_x;
					a_y_q <= rd_y;
					i_q   <= i_q + PW'(1);
				end
				if (go_seg) begin
					b_x_q <= rd_x;
					b_y_q <= rd_y;
				end
				res_y_q    <= fin_y;
				res_fail_q <= fin_fail;
			end
			pwli_pkg::ST_DIFF: begin
				dx_q <= {x_q[DW-1], x_q} - {a_x_q[DW-1], a_x_q};
				dy_q <= {b_y_q[DW-1], b_y_q} - {a_y_q[DW-1], a_y_q};
				dd_q <= {b_x_q[DW-1], b_x_q} - {a_x_q[DW-1], a_x_q};
			end
			pwli_pkg::ST_SCALE: begin
				neg_q      <= dx_q[DW] ^ dy_q[DW] ^ dd_q[DW];
				res_y_q    <= a_y_q;
				res_fail_q <= 1'b0;
			end
			pwli_pkg::ST_DIV: begin
				if (md_rsp.done) begin
					res_y_q <= neg_q ? a_y_q - md_rsp.quot : a_y_q + md_rsp.quot;
				end
			end
			default: begin
			end
		endcase
	end

	// output register, refilled as soon as the held result transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == pwli_pkg::ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pwli_pkg::ST_FINISH && out_free) begin
			out_y_q    <= res_y_q;
			out_fail_q <= res_fail_q;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.y_result = out_y_q;
	assign rsp.failed   = out_fail_q;

endmodule

### src/pwli_checker.sv
`include "assert_macros.svh"

module pwli_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [pwli_pkg::DATA_W-1:0] y_result,
	input logic                        failed
);

	logic [1:0] pend_q;
	logic       req_xfer, rsp_xfer;

	assign req_xfer = req_valid && req_ready;
	assign rsp_xfer = rsp_valid && rsp_ready;

	// items taken whose result has not transferred yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else if (req_xfer && !rsp_xfer) begin
			pend_q <= pend_q + 2'd1;
		end else if (rsp_xfer && !req_xfer) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	`CHK_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`CHK_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(y_result) && $stable(failed))
	`CHK_IMPLY(a_fail_zero, clk, arst_n, rsp_valid && failed, y_result == '0)
	`CHK_IMPLY(a_no_orphan, clk, arst_n, rsp_valid, pend_q != 2'd0)
	`CHK_IMPLY(a_pend_bound, clk, arst_n, 1'b1, pend_q != 2'd3)

endmodule

bind piecewise_linear_table_interp_core pwli_checker u_pwli_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.y_result  (rsp.y_result),
	.failed    (rsp.failed)
);

### verif/tb.sv
module tb;
	import pwli_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [1:0] EDGE_UNDEF = 2'd3;

	typedef struct packed {
		logic [DATA_W-1:0] y;
		logic              failed;
	} interp_res_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	pwli_req_if req_ch ();
	pwli_rsp_if rsp_ch ();

	piecewise_linear_table_interp_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// own copy of the table and the registers
	logic signed [DATA_W-1:0] tbl_x [MAX_POINTS];
	logic signed [DATA_W-1:0] tbl_y [MAX_POINTS];
	logic [CFG_W-1:0]         reg_count;
	logic [1:0]               reg_mode;

	interp_res_t interp_due [$];
	interp_res_t got_due;
	int          mismatches = 0;
	int unsigned cycle_count = 0;
	bit          src_idle;
	bit          sink_idle;
	bit          hold_rsp;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int points_in_use();
		if (reg_count < 2)
			return 2;
		if (reg_count > MAX_POINTS)
			return MAX_POINTS;
		return reg_count;
	endfunction

	function automatic logic [DATA_W-1:0] segment_value(input int i, input longint qx);
		longint      dx, dy, dd;
		logic [63:0] mdx, mdy, prod, den, q, r;
		logic        neg;
		dx = qx - longint'(tbl_x[i]);
		dy = longint'(tbl_y[i+1]) - longint'(tbl_y[i]);
		dd = longint'(tbl_x[i+1]) - longint'(tbl_x[i]);
		if (dd == 0)
			return tbl_y[i];
		mdx = (dx < 0) ? -dx : dx;
		mdy = (dy < 0) ? -dy : dy;
		den = (dd < 0) ? -dd : dd;
		prod = mdx * mdy;
		q = prod / den;
		r = prod % den;
		// round to nearest, ties away from zero
		if (r * 2 >= den)
			q = q + 1;
		neg = ((dx < 0) != (dy < 0)) != (dd < 0);
		return neg ? tbl_y[i] - q[DATA_W-1:0] : tbl_y[i] + q[DATA_W-1:0];
	endfunction

	function automatic interp_res_t predict_lookup(input logic signed [DATA_W-1:0] qx);
		interp_res_t res;
		int          n, i;
		longint      x, a, b;
		res.y = '0;
		res.failed = 1'b0;
		n = points_in_use();
		x = qx;
		a = tbl_x[0];
		b = tbl_x[1];
		if (x == a) begin
			res.y = tbl_y[0];
			return res;
		end
		if (x == b) begin
			res.y = tbl_y[1];
			return res;
		end
		// below the first point
		if ((x < a) == (a < b)) begin
			if (reg_mode == EDGE_ERROR)
				res.failed = 1'b1;
			else if (reg_mode == EDGE_CLIP)
				res.y = tbl_y[0];
			else
				res.y = segment_value(0, x);
			return res;
		end
		i = 0;
		forever begin
			a = tbl_x[i];
			b = tbl_x[i+1];
			if (x == a) begin
				res.y = tbl_y[i];
				return res;
			end
			if (x == b) begin
				res.y = tbl_y[i+1];
				return res;
			end
			if ((x > a) != (x > b))
				break;
			if (i + 2 >= n)
				break;
			i++;
		end
		// beyond the last segment walked
		if ((x > b) == (b > a)) begin
			if (reg_mode == EDGE_ERROR) begin
				res.failed = 1'b1;
				return res;
			end
			if (reg_mode == EDGE_CLIP) begin
				res.y = tbl_y[i+1];
				return res;
			end
		end
		res.y = segment_value(i, x);
		return res;
	endfunction

	function automatic logic [DATA_W-1:0] pick_query();
		int          n, k;
		longint      lo, hi, off;
		logic [63:0] rnd;
		n = points_in_use();
		k = $urandom_range(0, n - 2);
		rnd = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0, 1: return tbl_x[k + $urandom_range(0, 1)];
			2: return $urandom_range(0, 1) ? tbl_x[k] + 32'sd1 : tbl_x[k] - 32'sd1;
			3, 4: begin
				lo = tbl_x[k];
				hi = tbl_x[k+1];
				if (lo > hi) begin
					off = lo;
					lo = hi;
					hi = off;
				end
				return 32'(lo + longint'(rnd % (hi - lo + 1)));
			end
			5: begin
				off = $urandom_range(1, 1000);
				lo = $urandom_range(0, 1) ? tbl_x[0] : tbl_x[n-1];
				return $urandom_range(0, 1) ? 32'(lo + off) : 32'(lo - off);
			end
			6: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %h, got %h", what, want, got);
	endtask

	// result transfer check
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (interp_due.size() == 0) begin
				flag_mismatch("unexpected result", '0, rsp_ch.y_result);
			end else begin
				got_due = interp_due.pop_front();
				if (rsp_ch.y_result !== got_due.y)
					flag_mismatch("y_result", got_due.y, rsp_ch.y_result);
				if (rsp_ch.failed !== got_due.failed)
					flag_mismatch("failed", DATA_W'(got_due.failed), DATA_W'(rsp_ch.failed));
			end
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
				rsp_ch.ready <= 1'b1;
			end else if (sink_idle && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input func_t f, input logic [IDX_W-1:0] idx,
			input logic signed [DATA_W-1:0] xv, input logic signed [DATA_W-1:0] yv);
		interp_res_t res;
		if (src_idle && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.point_index <= idx;
		req_ch.x_value <= xv;
		req_ch.y_value <= yv;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		// transfer taken at this edge
		res.y = '0;
		res.failed = 1'b0;
		if (f == FUNC_WRITE) begin
			tbl_x[idx] = xv;
			tbl_y[idx] = yv;
		end else begin
			res = predict_lookup(xv);
		end
		interp_due.push_back(res);
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (interp_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (r == REG_POINT_COUNT)
			reg_count = v;
		else
			reg_mode = v[1:0];
	endtask

	task automatic run_table_round(input bit scrambled, input int lookups);
		logic [CFG_W-1:0]         cnt;
		int                       n, j, k, y_kind;
		bit                       falling, backward;
		longint                   step_max, span, pos;
		logic [63:0]              rnd;
		logic signed [DATA_W-1:0] px [MAX_POINTS];
		logic signed [DATA_W-1:0] py [MAX_POINTS];
		case ($urandom_range(0, 9))
			0: cnt = CFG_W'(2);
			1: cnt = CFG_W'(MAX_POINTS);
			2: cnt = $urandom_range(0, 1) ? CFG_W'($urandom_range(0, 1)) :
				CFG_W'($urandom_range(17, 31));
			default: cnt = CFG_W'($urandom_range(2, MAX_POINTS));
		endcase
		n = (cnt < 2) ? 2 : ((cnt > MAX_POINTS) ? MAX_POINTS : cnt);
		case ($urandom_range(0, 2))
			0: step_max = $urandom_range(1, 4);
			1: step_max = $urandom_range(5, 100000);
			default: step_max = 64'hffff_ffff / (n - 1);
		endcase
		span = 64'hffff_ffff - (n - 1) * step_max;
		rnd = {$urandom, $urandom};
		pos = longint'(rnd % (span + 1)) - 64'sd2147483648;
		falling = $urandom_range(0, 1);
		y_kind = $urandom_range(0, 2);
		for (j = 0; j < n; j++) begin
			k = falling ? n - 1 - j : j;
			px[k] = scrambled ? DATA_W'($urandom) : pos[DATA_W-1:0];
			case (y_kind)
				0: py[k] = $urandom;
				1: py[k] = $urandom_range(0, 2000) - 1000;
				default: py[k] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			endcase
			rnd = {$urandom, $urandom};
			// an occasional zero step gives a flat segment
			if ($urandom_range(0, 7) != 0)
				pos += 1 + longint'(rnd % step_max);
		end
		backward = $urandom_range(0, 1);
		for (j = 0; j < n; j++) begin
			k = backward ? n - 1 - j : j;
			send_item(FUNC_WRITE, k[IDX_W-1:0], px[k], py[k]);
		end
		write_reg(REG_POINT_COUNT, cnt);
		write_reg(REG_EDGE_MODE, CFG_W'($urandom));
		for (j = 0; j < lookups; j++) begin
			if (scrambled && $urandom_range(0, 3) == 0)
				send_item(FUNC_WRITE, IDX_W'($urandom_range(0, n - 1)), $urandom, $urandom);
			else
				send_item(FUNC_LOOKUP, IDX_W'($urandom), pick_query(), $urandom);
		end
	endtask

	task automatic test_directed_cases();
		// full-range segment under the reset settings
		send_item(FUNC_WRITE, 4'd0, 32'sh8000_0000, 32'sh7fff_ffff);
		send_item(FUNC_WRITE, 4'd1, 32'sh7fff_ffff, 32'sh8000_0000);
		send_item(FUNC_LOOKUP, 4'd15, 32'sd0, 32'sh7fff_ffff);
		send_item(FUNC_LOOKUP, 4'd0, 32'sh8000_0000, 32'sh8000_0000);
		send_item(FUNC_LOOKUP, 4'd0, 32'sh7fff_ffff, 32'sd0);
		send_item(FUNC_WRITE, 4'd15, 32'sd12345, -32'sd7);
		// rising table with a flat segment in the middle
		send_item(FUNC_WRITE, 4'd0, -32'sd100, 32'sd10);
		send_item(FUNC_WRITE, 4'd1, 32'sd100, 32'sd20);
		send_item(FUNC_WRITE, 4'd2, 32'sd100, 32'sd50);
		send_item(FUNC_WRITE, 4'd3, 32'sd300, -32'sd1000);
		write_reg(REG_POINT_COUNT, 5'd4);
		send_item(FUNC_LOOKUP, 4'd0, -32'sd90, 32'sd0);
		send_item(FUNC_LOOKUP, 4'd0, -32'sd200, 32'sd0);
		send_item(FUNC_LOOKUP, 4'd0, 32'sd400, 32'sd0);
		send_item(FUNC_LOOKUP, 4'd0, 32'sd100, 32'sd0);
		send_item(FUNC_LOOKUP, 4'd0, 32'sd200, 32'sd0);
		write_reg(REG_EDGE_MODE, EDGE_ERROR);
		send_item(FUNC_LOOKUP, 4'd0, -32'sd200, 32'sd0);
		send_item(FUNC_LOOKUP, 4'd0, 32'sd400, 32'sd0);
		write_reg(REG_EDGE_MODE, EDGE_EXTRAP);
		send_item(FUNC_LOOKUP, 4'd0, -32'sd110, 32'sd0);
		send_item(FUNC_LOOKUP, 4'd0, 32'sd400, 32'sd0);
		write_reg(REG_EDGE_MODE, EDGE_UNDEF);
		send_item(FUNC_LOOKUP, 4'd0, 32'sh7fff_ffff, 32'sd0);
		send_item(FUNC_LOOKUP, 4'd0, 32'sh8000_0000, 32'sd0);
		// count below range acts as two points
		write_reg(REG_POINT_COUNT, 5'd0);
		write_reg(REG_EDGE_MODE, EDGE_CLIP);
		send_item(FUNC_LOOKUP, 4'd0, 32'sd400, 32'sd0);
		// falling pair whose extrapolation wraps
		send_item(FUNC_WRITE, 4'd0, 32'sd10, 32'sh7fff_ffff);
		send_item(FUNC_WRITE, 4'd1, -32'sd10, 32'sh8000_0000);
		write_reg(REG_EDGE_MODE, EDGE_EXTRAP);
		send_item(FUNC_LOOKUP, 4'd0, -32'sd20, 32'sd0);
		send_item(FUNC_LOOKUP, 4'd0, 32'sd30, 32'sd0);
	endtask

	task automatic test_monotonic_tables(input int rounds);
		int r;
		for (r = 0; r < rounds; r++) begin
			src_idle = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			run_table_round(1'b0, 28);
		end
	endtask

	task automatic test_output_hold();
		int j;
		settle();
		hold_rsp = 1'b1;
		for (j = 0; j < 24; j++)
			send_item(FUNC_LOOKUP, IDX_W'($urandom), pick_query(), $urandom);
		settle();
	endtask

	task automatic test_scrambled_tables(input int rounds);
		int r;
		for (r = 0; r < rounds; r++) begin
			src_idle = ($urandom_range(0, 1) != 0);
			sink_idle = ($urandom_range(0, 1) != 0);
			run_table_round(1'b1, 28);
		end
	endtask

	task automatic test_steady_tail(input int rounds);
		int r;
		src_idle = 1'b0;
		sink_idle = 1'b0;
		for (r = 0; r < rounds; r++)
			run_table_round(1'b0, 28);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_POINT_COUNT;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_WRITE;
		req_ch.point_index = '0;
		req_ch.x_value = '0;
		req_ch.y_value = '0;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		hold_rsp = 1'b0;
		reg_count = CFG_W'(2);
		reg_mode = EDGE_CLIP;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_monotonic_tables(22);
		test_output_hold();
		test_scrambled_tables(3);
		test_steady_tail(4);
		settle();
		repeat (64) @(posedge clk);
		if (mismatches == 0 && interp_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
